>>> rtl/core/hmm_pkg.sv
// ----------------------------------------------------------------------------
// hmm_pkg
// Shared types, constants and codes of the hashed multimap engine.
// ----------------------------------------------------------------------------
package hmm_pkg;

  // Table geometry
  localparam int BUCKETS  = 256;
  localparam int WAYS     = 4;
  localparam int ROW_AW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CW   = $clog2(WAYS + 1);

  // Register and field widths
  localparam int BC_W     = 9;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 8;
  localparam logic [BC_W-1:0] BC_RESET = BC_W'(BUCKETS);

  // Remainder unit: key bits handled per cycle and cycle count
  localparam int DIV_STEP  = 4;
  localparam int DIV_BITS  = 32;
  localparam int DIV_ITER  = DIV_BITS / DIV_STEP;
  localparam int DIV_CW    = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

  // Register addresses
  localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

  // Operation codes
  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_GET     = 3'd1,
    FN_GET_NTH = 3'd2,
    FN_DEL_ONE = 3'd3,
    FN_DEL_ALL = 3'd4,
    FN_COUNT   = 3'd5
  } func_t;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] match_count;
    logic [1:0]       status;
  } result_t;

endpackage

>>> rtl/core/hmm_ram.sv
// ----------------------------------------------------------------------------
// hmm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/hmm_div.sv
// ----------------------------------------------------------------------------
// hmm_div
// Iterative remainder unit: key modulo bucket count, DIV_STEP bits a cycle.
// ----------------------------------------------------------------------------
module hmm_div import hmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [BC_W-1:0]  divisor,
  output logic             done,
  output logic [BC_W-1:0]  remainder
);

  logic                busy;
  logic [DIV_CW-1:0]   cnt;
  logic [DIV_BITS-1:0] quo;
  logic [BC_W-1:0]     dvs;
  logic [BC_W-1:0]     rem_next;

  // DIV_STEP restoring steps on narrow values
  always_comb begin
    logic [BC_W:0] t;
    rem_next = remainder;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {rem_next, quo[DIV_BITS-1-i]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      rem_next = t[BC_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= DIV_BITS'(dividend);
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo       <= quo << DIV_STEP;
      remainder <= rem_next;
    end
  end

endmodule

>>> rtl/core/hmm_row.sv
// ----------------------------------------------------------------------------
// hmm_row
// Row update logic: applies one operation to a bucket row of WAYS slots.
// ----------------------------------------------------------------------------
module hmm_row import hmm_pkg::*; (
  input  row_t             row,
  input  logic [2:0]       func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] item_value,
  input  logic [7:0]       position,
  input  logic             reject,
  output row_t             row_next,
  output logic             wr,
  output result_t          res
);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] remove;

  // Per-slot key compare
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row[w].used && (row[w].key == key);
    end
  end

  always_comb begin
    logic [CNT_W-1:0]  n;
    logic              hit;
    logic [WAY_CW-1:0] idx;
    row_t              packed_row;
    row_t              shifted;

    res      = '0;
    wr       = 1'b0;
    row_next = row;
    remove   = '0;
    n        = '0;
    hit      = 1'b0;
    idx      = '0;
    packed_row = '0;
    shifted    = '0;

    // Slots to drop: first match or all matches
    for (int w = 0; w < WAYS; w++) begin
      if (match[w] && !hit) begin
        remove[w] = 1'b1;
        hit       = 1'b1;
      end else if (match[w] && (func == FN_DEL_ALL)) begin
        remove[w] = 1'b1;
      end
    end

    // Pack the kept slots toward the head
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].used && !remove[w]) begin
        packed_row[idx[WAY_IW-1:0]] = row[w];
        idx = idx + 1'b1;
      end
    end

    // Insert shifts the row down by one
    shifted[0] = '{used: 1'b1, key: key, value: item_value};
    for (int w = 1; w < WAYS; w++) begin
      shifted[w] = row[w-1];
    end

    hit = 1'b0;
    if (reject) begin
      res.status = ST_REJECT;
    end else begin
      case (func)
        FN_INSERT: begin
          if (row[WAYS-1].used) begin
            res.status = ST_FULL;
          end else begin
            row_next = shifted;
            wr       = 1'b1;
          end
        end
        FN_GET, FN_GET_NTH: begin
          for (int w = 0; w < WAYS; w++) begin
            if (match[w] && !hit) begin
              if (func == FN_GET || n == position) begin
                hit             = 1'b1;
                res.found       = 1'b1;
                res.found_value = row[w].value;
              end
              n = n + 1'b1;
            end
          end
        end
        FN_DEL_ONE, FN_DEL_ALL: begin
          if (|match) begin
            res.found = 1'b1;
            row_next  = packed_row;
            wr        = 1'b1;
          end
        end
        FN_COUNT: begin
          for (int w = 0; w < WAYS; w++) begin
            n = n + CNT_W'(match[w]);
          end
          res.match_count = n;
        end
        default: begin
          res.status = ST_REJECT;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/hashed_multimap_engine.sv
// ----------------------------------------------------------------------------
// hashed_multimap_engine
// Multimap from a non-negative 31-bit key to a 32-bit value handle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func, key, item_value, position;
//   output channel (out_valid/out_stall) returns one result per transaction:
//   found, found_value, match_count, status.
//   Each bucket is one row of WAYS slots in a single RAM, newest first.
//   The bucket index is key modulo bucket_count, worked out by a remainder
//   unit that takes 4 key bits a cycle, followed by a RAM read and an
//   update/write-back step.
//   One transaction is in flight at a time: the next is taken in the cycle
//   after the result is loaded, so throughput is bounded by the remainder
//   unit and the row read-modify-write.
//   in_stall stays high while a transaction is in work. A finished result
//   sits in the output register; while out_stall holds it there, the next
//   transaction is still taken and waits in its update cycle.
//   Reset empties every bucket at once through per-row valid flops (no
//   clearing pass) and sets bucket_count to 256. The user writes it via APB
//   at address 0 only while the engine is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module hashed_multimap_engine import hmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // APB configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       func,
  input  logic signed [31:0] key,
  input  logic [31:0]      item_value,
  input  logic [7:0]       position,
  // Output channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [31:0]      found_value,
  output logic [7:0]       match_count,
  output logic [1:0]       status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OP   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [BC_W-1:0]  bucket_count;
  logic [BC_W-1:0]  divisor;

  logic [2:0]       op_func;
  logic [KEY_W-1:0] op_key;
  logic [VAL_W-1:0] op_value;
  logic [7:0]       op_pos;
  logic             rejected;

  logic             accept;
  logic             div_done;
  logic [BC_W-1:0]  div_rem;
  logic [ROW_AW-1:0] row_idx;
  logic [BUCKETS-1:0] row_valid;
  logic             row_was_valid;

  row_t             ram_rdata;
  row_t             row_cur;
  row_t             row_new;
  logic             row_wr;
  result_t          res;
  logic             load_out;
  logic             ram_we;

  // APB register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_BUCKET_COUNT) begin
      bucket_count <= pwdata[BC_W-1:0];
    end
  end
  assign prdata = (paddr == ADDR_BUCKET_COUNT) ? {{(32-BC_W){1'b0}}, bucket_count} : '0;

  // Effective divisor: zero reads as one, saturated to BUCKETS
  always_comb begin
    if (bucket_count == '0) begin
      divisor = BC_W'(1);
    end else if (bucket_count > BC_RESET) begin
      divisor = BC_RESET;
    end else begin
      divisor = bucket_count;
    end
  end

  // Input capture
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= func;
      op_key   <= key[KEY_W-1:0];
      op_value <= item_value;
      op_pos   <= position;
      rejected <= key[31] || (func > FN_COUNT) ||
                  (func == FN_INSERT && item_value == '0);
    end
  end

  // Bucket index unit
  hmm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (key[KEY_W-1:0]),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      row_idx       <= div_rem[ROW_AW-1:0];
      row_was_valid <= row_valid[div_rem[ROW_AW-1:0]];
    end
  end

  // Row storage
  hmm_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_idx),
    .wdata (row_new),
    .re    (div_done),
    .raddr (div_rem[ROW_AW-1:0]),
    .rdata (ram_rdata)
  );

  // A row never written reads as empty
  assign row_cur = row_was_valid ? ram_rdata : '0;

  hmm_row u_row (
    .row        (row_cur),
    .func       (op_func),
    .key        (op_key),
    .item_value (op_value),
    .position   (op_pos),
    .reject     (rejected),
    .row_next   (row_new),
    .wr         (row_wr),
    .res        (res)
  );

  assign load_out = (state == S_OP) && (!out_valid || !out_stall);
  assign ram_we   = load_out && row_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[row_idx] <= 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_OP;
      S_OP:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found       <= res.found;
      found_value <= res.found_value;
      match_count <= res.match_count;
      status      <= res.status;
    end
  end

  // Checks
  a_write_in_op: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_OP)
    else $error("row write outside update cycle");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !rejected)
    else $error("rejected transaction wrote a row");

  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DIV)
    else $error("accepted transaction did not start the remainder unit");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("remainder done outside divide phase");

endmodule
